/* hdl/rpc_message_deframer_unit_macros.svh */
// ----------------------------------------------------------------------------
// RPC message deframer assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RPC_MESSAGE_DEFRAMER_UNIT_MACROS_SVH
`define RPC_MESSAGE_DEFRAMER_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When pre holds at one edge, post must hold at the next edge.
`define RMD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hdl/rmd_pkg.sv */
// ----------------------------------------------------------------------------
// RPC message deframer package
// Shared types and constants of the deframer front end, queue and back end.
// ----------------------------------------------------------------------------
package rmd_pkg;

  // Frame layout.
  localparam int unsigned PRE_METHOD   = 8;   // type, status, id, length field
  localparam int unsigned LEN_BYTES    = 4;   // body length field
  localparam int unsigned FIXED_HEADER = PRE_METHOD + LEN_BYTES;

  localparam int unsigned COUNT_W = 34;       // saturating byte counter
  localparam int unsigned HLEN_W  = 18;       // header length up to 12 + 65535
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register defaults.
  localparam logic [7:0]  REQ_CODE_RST     = 8'd1;
  localparam logic [7:0]  RESP_CODE_RST    = 8'd2;
  localparam logic [15:0] METHOD_LIMIT_RST = 16'd64;
  localparam logic [31:0] BODY_LIMIT_RST   = 32'd65536;

  typedef enum logic [1:0] {
    CFG_REQ_CODE     = 2'd0,
    CFG_RESP_CODE    = 2'd1,
    CFG_METHOD_LIMIT = 2'd2,
    CFG_BODY_LIMIT   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_METHOD = 2'd1,
    KIND_BODY   = 2'd2,
    KIND_TRAIL  = 2'd3
  } byte_kind_e;

  // One classified byte together with the frame state after it.
  typedef struct packed {
    byte_kind_e           kind;
    logic [7:0]           data;
    logic                 last;
    logic                 failed;
    logic                 resp;
    logic [31:0]          id;
    logic [7:0]           status;
    logic [15:0]          mlen;
    logic [31:0]          blen;
    logic [COUNT_W-1:0]   count;
  } rmd_entry_t;

endpackage

/* hdl/rmd_ifs.sv */
// ----------------------------------------------------------------------------
// RPC message deframer channel interfaces
// Valid/ready channels for incoming frame bytes and outgoing tagged results.
// ----------------------------------------------------------------------------
interface rmd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rmd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_kind;
  logic [7:0]  byte_value;
  logic        frame_end;
  logic        frame_ok;
  logic        is_response;
  logic [31:0] rpc_id;
  logic [7:0]  status_code;
  logic [15:0] method_length;
  logic [31:0] body_length;

  modport source (
    output valid, output byte_kind, output byte_value, output frame_end,
    output frame_ok, output is_response, output rpc_id, output status_code,
    output method_length, output body_length, input ready
  );
  modport sink (
    input valid, input byte_kind, input byte_value, input frame_end,
    input frame_ok, input is_response, input rpc_id, input status_code,
    input method_length, input body_length, output ready
  );
endinterface

/* hdl/rmd_front.sv */
// ----------------------------------------------------------------------------
// RPC message deframer front end
// Holds the configuration registers, classifies each byte and tracks header state.
// ----------------------------------------------------------------------------
`include "rpc_message_deframer_unit_macros.svh"

module rmd_front import rmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  rmd_byte_if.sink    byte_i,
  input  logic        q_full_i,
  output logic        push_o,
  output rmd_entry_t  entry_o
);

  logic [7:0]         req_code_q, resp_code_q;
  logic [15:0]        method_limit_q;
  logic [31:0]        body_limit_q;

  logic [COUNT_W-1:0] count_q, count_d, count_upd;
  logic               resp_q, resp_d, resp_upd;
  logic               failed_q, failed_d, failed_upd;
  logic [7:0]         status_q, status_d, status_upd;
  logic [31:0]        id_q, id_d, id_upd;
  logic [15:0]        ml_q, ml_d, ml_upd;
  logic [31:0]        bl_q, bl_d, bl_upd;
  logic [31:0]        shift_q, shift_d, shift_upd;

  logic               accept;
  logic [7:0]         data;
  logic               last;
  logic [HLEN_W-1:0]  hlen, meth_end;
  logic [COUNT_W-1:0] body_off;
  logic [31:0]        shift_new;
  byte_kind_e         kind;

  assign byte_i.ready = !q_full_i;
  assign accept       = byte_i.valid && !q_full_i;
  assign data         = byte_i.data_byte;
  assign last         = byte_i.last_byte;
  assign push_o       = accept;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_code_q     <= REQ_CODE_RST;
      resp_code_q    <= RESP_CODE_RST;
      method_limit_q <= METHOD_LIMIT_RST;
      body_limit_q   <= BODY_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_REQ_CODE:     req_code_q     <= cfg_data_i[7:0];
        CFG_RESP_CODE:    resp_code_q    <= cfg_data_i[7:0];
        CFG_METHOD_LIMIT: method_limit_q <= cfg_data_i[15:0];
        CFG_BODY_LIMIT:   body_limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    hlen      = resp_q ? HLEN_W'(FIXED_HEADER) : HLEN_W'(FIXED_HEADER) + {2'b00, ml_q};
    meth_end  = HLEN_W'(PRE_METHOD) + {2'b00, ml_q};
    body_off  = count_q - COUNT_W'(hlen);
    shift_new = {shift_q[23:0], data};

    if (failed_q)                                     kind = KIND_TRAIL;
    else if (count_q < COUNT_W'(PRE_METHOD))          kind = KIND_HEADER;
    else if (!resp_q && count_q < COUNT_W'(meth_end)) kind = KIND_METHOD;
    else if (count_q < COUNT_W'(hlen))                kind = KIND_HEADER;
    else if (body_off < COUNT_W'(bl_q))               kind = KIND_BODY;
    else                                              kind = KIND_TRAIL;

    resp_upd   = resp_q;
    failed_upd = failed_q;
    status_upd = status_q;
    id_upd     = id_q;
    ml_upd     = ml_q;
    bl_upd     = bl_q;
    shift_upd  = shift_q;

    if (kind == KIND_HEADER) begin
      if (count_q >= COUNT_W'(2)) shift_upd = shift_new;
      if (count_q == COUNT_W'(0)) begin
        if (data == req_code_q)       resp_upd   = 1'b0;
        else if (data == resp_code_q) resp_upd   = 1'b1;
        else                          failed_upd = 1'b1;
      end else if (count_q == COUNT_W'(1)) begin
        if (resp_q) status_upd = data;
      end else if (count_q == COUNT_W'(5)) begin
        id_upd = shift_new;
      end else if (count_q == COUNT_W'(7)) begin
        if (resp_q) begin
          // Reserved field of a response must be zero.
          if (shift_new[15:0] != 16'd0) failed_upd = 1'b1;
        end else begin
          ml_upd = shift_new[15:0];
          if (shift_new[15:0] == 16'd0 || shift_new[15:0] > method_limit_q) begin
            failed_upd = 1'b1;
          end
        end
      end else if (count_q >= COUNT_W'(PRE_METHOD) &&
                   count_q == COUNT_W'(hlen - HLEN_W'(1))) begin
        bl_upd = shift_new;
        if (shift_new > body_limit_q) failed_upd = 1'b1;
      end
    end

    count_upd = (&count_q) ? count_q : count_q + COUNT_W'(1);

    entry_o.kind   = kind;
    entry_o.data   = data;
    entry_o.last   = last;
    entry_o.failed = failed_upd;
    entry_o.resp   = resp_upd;
    entry_o.id     = id_upd;
    entry_o.status = status_upd;
    entry_o.mlen   = ml_upd;
    entry_o.blen   = bl_upd;
    entry_o.count  = count_upd;

    count_d  = count_q;
    resp_d   = resp_q;
    failed_d = failed_q;
    status_d = status_q;
    id_d     = id_q;
    ml_d     = ml_q;
    bl_d     = bl_q;
    shift_d  = shift_q;
    if (accept) begin
      if (last) begin
        // The final byte closes the frame; start the next one clean.
        count_d  = '0;
        resp_d   = 1'b0;
        failed_d = 1'b0;
        status_d = '0;
        id_d     = '0;
        ml_d     = '0;
        bl_d     = '0;
        shift_d  = '0;
      end else begin
        count_d  = count_upd;
        resp_d   = resp_upd;
        failed_d = failed_upd;
        status_d = status_upd;
        id_d     = id_upd;
        ml_d     = ml_upd;
        bl_d     = bl_upd;
        shift_d  = shift_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      resp_q   <= 1'b0;
      failed_q <= 1'b0;
      status_q <= '0;
      id_q     <= '0;
      ml_q     <= '0;
      bl_q     <= '0;
      shift_q  <= '0;
    end else begin
      count_q  <= count_d;
      resp_q   <= resp_d;
      failed_q <= failed_d;
      status_q <= status_d;
      id_q     <= id_d;
      ml_q     <= ml_d;
      bl_q     <= bl_d;
      shift_q  <= shift_d;
    end
  end

  `RMD_ASSERT_NEXT(a_clear_after_last, accept && last, count_q == '0 && !failed_q,
                   "frame state not cleared after final byte")
  `RMD_ASSERT(a_failed_is_trail, accept && failed_q |-> entry_o.kind == KIND_TRAIL,
              "byte of a failed frame not tagged trailing")

endmodule

/* hdl/rmd_queue.sv */
// ----------------------------------------------------------------------------
// RPC message deframer queue
// Small first-in first-out buffer between the classifier and the result stage.
// ----------------------------------------------------------------------------
`include "rpc_message_deframer_unit_macros.svh"

module rmd_queue import rmd_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rmd_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output rmd_entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rmd_entry_t       mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i)      count_d = count_q + CntW'(1);
    else if (pop_i && !push_i) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  `RMD_ASSERT(a_q_bounded, count_q <= CntW'(Depth), "queue occupancy above its depth")
  `RMD_ASSERT_NEXT(a_q_grow, push_i && !pop_i, count_q == $past(count_q) + CntW'(1), "queue occupancy did not grow on push")

endmodule

/* hdl/rmd_back.sv */
// ----------------------------------------------------------------------------
// RPC message deframer back end
// Decides pass or fail on the final byte and holds the result register.
// ----------------------------------------------------------------------------
module rmd_back import rmd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  rmd_entry_t   q_data_i,
  output logic         pop_o,
  rmd_result_if.source result_o
);

  logic               valid_q;
  logic [1:0]         kind_q;
  logic [7:0]         value_q;
  logic               end_q, ok_q, resp_q;
  logic [31:0]        id_q;
  logic [7:0]         status_q;
  logic [15:0]        ml_q;
  logic [31:0]        bl_q;

  logic [HLEN_W-1:0]  hlen;
  logic [COUNT_W-1:0] rem;
  logic               ok, lst;

  assign pop_o = q_valid_i && (!valid_q || result_o.ready);
  assign lst   = q_data_i.last;

  // A frame passes when it did not fail and carried its whole declared body.
  always_comb begin
    hlen = q_data_i.resp ? HLEN_W'(FIXED_HEADER)
                         : HLEN_W'(FIXED_HEADER) + {2'b00, q_data_i.mlen};
    rem  = q_data_i.count - COUNT_W'(hlen);
    ok   = !q_data_i.failed && (q_data_i.count >= COUNT_W'(hlen)) &&
           (rem >= COUNT_W'(q_data_i.blen));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (result_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= q_data_i.kind;
      value_q  <= q_data_i.data;
      end_q    <= lst;
      ok_q     <= lst && ok;
      resp_q   <= lst && q_data_i.resp;
      id_q     <= lst ? q_data_i.id : 32'd0;
      status_q <= (lst && q_data_i.resp) ? q_data_i.status : 8'd0;
      ml_q     <= (lst && !q_data_i.resp) ? q_data_i.mlen : 16'd0;
      bl_q     <= lst ? q_data_i.blen : 32'd0;
    end
  end

  assign result_o.valid         = valid_q;
  assign result_o.byte_kind     = kind_q;
  assign result_o.byte_value    = value_q;
  assign result_o.frame_end     = end_q;
  assign result_o.frame_ok      = ok_q;
  assign result_o.is_response   = resp_q;
  assign result_o.rpc_id        = id_q;
  assign result_o.status_code   = status_q;
  assign result_o.method_length = ml_q;
  assign result_o.body_length   = bl_q;

endmodule

/* hdl/rpc_message_deframer_unit.sv */
// ----------------------------------------------------------------------------
// Path: an accepted byte is written into the queue, then moved into the
// result register, from which it is offered on the result channel.
// Throughput: one byte per clock while the queue has room.
// The queue between classifier and result register absorbs output stalls.
// Reset: configuration returns to its defaults, frame state is cleared and
// the queue and output register empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
// RPC message deframer
// Tags each received frame byte and reports the parsed header on the last byte.
// ----------------------------------------------------------------------------
module rpc_message_deframer_unit import rmd_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  rmd_byte_if.sink     byte_i,
  rmd_result_if.source result_o
);

  // The front end takes one byte transaction per cycle while the queue has
  // room. It works out the byte kind from the running byte count and the
  // header fields seen so far, updates the frame state, and pushes the byte
  // together with a snapshot of that state into the queue.
  logic       push, q_full, q_valid, pop;
  rmd_entry_t push_entry, pop_entry;

  rmd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .byte_i     (byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // The queue decouples the two halves, so a stalled result transaction does
  // not stop new bytes until the queue itself fills.
  rmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_entry)
  );

  // The back end settles pass or fail for the frame's final byte, zeroes the
  // header fields on every other result, and holds the output register.
  rmd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (pop_entry),
    .pop_o     (pop),
    .result_o  (result_o)
  );

endmodule

/* verif/tb_rpc_message_deframer_unit.sv */
// ----------------------------------------------------------------------------
// RPC message deframer testbench
// Sends request, response and malformed frames one byte at a time under
// several register settings, with random gaps on both channels and one long
// output stall. A scoreboard predicts the tag and the frame report of every
// byte and compares them with what the block returns.
// ----------------------------------------------------------------------------
module tb_rpc_message_deframer_unit import rmd_pkg::*; ();

  // Upper bound on the run. The slowest correct run is about 1850 bytes with
  // random gaps on both channels, plus the output stall and the pauses between
  // settings, so this leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 500000;
  // The output side stops accepting after this many results, for this long.
  localparam int unsigned HOLD_AFTER  = 700;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned MAX_GAP     = 18;

  // One result as the block reports it; the frame fields are zero except on
  // the final byte of a frame.
  typedef struct packed {
    byte_kind_e  kind;
    logic [7:0]  value;
    logic        frame_end;
    logic        ok;
    logic        resp;
    logic [31:0] id;
    logic [7:0]  status;
    logic [15:0] meth_len;
    logic [31:0] blen;
  } deframe_result_t;

  // Scoreboard: keeps its own copy of the registers and of the frame parser
  // state, works out the result of every accepted byte and checks the results
  // in order.
  class frame_tag_model;
    logic [7:0]         req_code;
    logic [7:0]         resp_code;
    logic [15:0]        method_max;
    logic [31:0]        body_max;
    logic [COUNT_W-1:0] pos_count;
    bit                 resp_frame;
    bit                 failed;
    logic [7:0]         status;
    logic [31:0]        id;
    logic [15:0]        meth_len;
    logic [31:0]        blen;
    logic [31:0]        shift_reg;
    deframe_result_t    expected_tags[$];
    int unsigned        mismatches;
    int unsigned        checked;

    function new();
      req_code    = REQ_CODE_RST;
      resp_code   = RESP_CODE_RST;
      method_max  = METHOD_LIMIT_RST;
      body_max    = BODY_LIMIT_RST;
      mismatches  = 0;
      checked     = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos_count  = '0;
      resp_frame = 1'b0;
      failed     = 1'b0;
      status     = '0;
      id         = '0;
      meth_len   = '0;
      blen       = '0;
      shift_reg  = '0;
    endfunction

    function logic [COUNT_W-1:0] header_len();
      return resp_frame ? COUNT_W'(FIXED_HEADER) : COUNT_W'(FIXED_HEADER) + meth_len;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_REQ_CODE:     req_code   = val[7:0];
        CFG_RESP_CODE:    resp_code  = val[7:0];
        CFG_METHOD_LIMIT: method_max = val[15:0];
        CFG_BODY_LIMIT:   body_max   = val;
        default: ;
      endcase
    endfunction

    // Called for every byte transaction accepted on the input channel.
    function void note_byte(logic [7:0] b, logic last);
      logic [COUNT_W-1:0] pos;
      logic [COUNT_W-1:0] hl;
      logic [15:0]        field16;
      byte_kind_e         kind;
      deframe_result_t    r;
      pos = pos_count;
      hl  = header_len();
      if (failed) kind = KIND_TRAIL;
      else if (pos < PRE_METHOD) kind = KIND_HEADER;
      else if (!resp_frame && pos < PRE_METHOD + meth_len) kind = KIND_METHOD;
      else if (pos < hl) kind = KIND_HEADER;
      else if (pos - hl < blen) kind = KIND_BODY;
      else kind = KIND_TRAIL;

      if (kind == KIND_HEADER) begin
        if (pos >= 2) shift_reg = {shift_reg[23:0], b};
        if (pos == 0) begin
          // A type byte that matches both codes counts as a request.
          if (b == req_code) resp_frame = 1'b0;
          else if (b == resp_code) resp_frame = 1'b1;
          else failed = 1'b1;
        end else if (pos == 1) begin
          if (resp_frame) status = b;
        end else if (pos == 5) begin
          id = shift_reg;
        end else if (pos == 7) begin
          field16 = shift_reg[15:0];
          if (resp_frame) begin
            if (field16 != 0) failed = 1'b1;
          end else begin
            meth_len = field16;
            if (field16 == 0 || field16 > method_max) failed = 1'b1;
          end
        end else if (pos >= PRE_METHOD && pos == hl - 1) begin
          blen = shift_reg;
          if (shift_reg > body_max) failed = 1'b1;
        end
      end

      if (pos_count != '1) pos_count++;

      r       = '0;
      r.kind  = kind;
      r.value = b;
      if (last) begin
        hl          = header_len();
        r.frame_end = 1'b1;
        r.ok        = !failed && pos_count >= hl && pos_count - hl >= blen;
        r.resp      = resp_frame;
        r.id        = id;
        r.status    = resp_frame ? status : 8'd0;
        r.meth_len  = resp_frame ? 16'd0 : meth_len;
        r.blen      = blen;
        clear_frame();
      end
      expected_tags.push_back(r);
    endfunction

    function string describe(deframe_result_t r);
      return $sformatf("kind=%0d byte=%02h end=%0b ok=%0b resp=%0b id=%08h status=%02h mlen=%0d blen=%0d",
                       r.kind, r.value, r.frame_end, r.ok, r.resp, r.id, r.status,
                       r.meth_len, r.blen);
    endfunction

    // Called for every result transaction accepted on the output channel.
    function void check_result(deframe_result_t got);
      deframe_result_t want;
      string           diff;
      if (expected_tags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: %s", checked, describe(got));
        checked++;
        return;
      end
      want = expected_tags.pop_front();
      diff = "";
      if (got.kind      !== want.kind)      diff = {diff, " byte_kind"};
      if (got.value     !== want.value)     diff = {diff, " byte_value"};
      if (got.frame_end !== want.frame_end) diff = {diff, " frame_end"};
      if (got.ok        !== want.ok)        diff = {diff, " frame_ok"};
      if (got.resp      !== want.resp)      diff = {diff, " is_response"};
      if (got.id        !== want.id)        diff = {diff, " rpc_id"};
      if (got.status    !== want.status)    diff = {diff, " status_code"};
      if (got.meth_len  !== want.meth_len)  diff = {diff, " method_length"};
      if (got.blen      !== want.blen)      diff = {diff, " body_length"};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d differs in%s", checked, diff);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
      checked++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [31:0] cfg_data_i;

  rmd_byte_if   byte_if ();
  rmd_result_if result_if ();

  frame_tag_model tag_model;

  // Register settings as the frame builder sees them; kept in step with the
  // scoreboard copy by the settings task.
  logic [7:0]  cur_req_code;
  logic [7:0]  cur_resp_code;
  logic [15:0] cur_method_max;
  logic [31:0] cur_body_max;

  logic [7:0]  frame_bytes[$];
  int unsigned sent_bytes;
  bit          send_burst;
  int unsigned cycle_count;

  rpc_message_deframer_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .byte_i     (byte_if),
    .result_o   (result_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offers one byte and returns at the edge where it is accepted. Every
  // input of the block is driven at a rising edge, and ready is sampled at
  // the edge, so the transaction is seen exactly where the block sees it.
  // Every forty bytes the sender decides whether to run back to back for a
  // while or to leave a random gap before each byte.
  task automatic send_byte(input logic [7:0] b, input logic l);
    int unsigned gap;
    if (sent_bytes % 40 == 0) send_burst = ($urandom_range(0, 2) == 0);
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= l;
    do @(posedge clk_i); while (byte_if.ready !== 1'b1);
    tag_model.note_byte(b, l);
    sent_bytes++;
  endtask

  task automatic send_frame();
    int unsigned i;
    for (i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Drops valid and waits until every expected result has come back, then
  // lets the pipeline settle before anything is reconfigured.
  task automatic wait_idle();
    byte_if.valid <= 1'b0;
    while (tag_model.expected_tags.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Leaves the write enable high so that back-to-back writes never lower and
  // raise it in the same time step; the caller drops it after the last one.
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tag_model.set_reg(idx, val);
  endtask

  task automatic apply_settings(input logic [7:0] rq, input logic [7:0] rs,
                                input logic [15:0] ml, input logic [31:0] bl);
    write_reg(CFG_REQ_CODE, 32'(rq));
    write_reg(CFG_RESP_CODE, 32'(rs));
    write_reg(CFG_METHOD_LIMIT, 32'(ml));
    write_reg(CFG_BODY_LIMIT, bl);
    cfg_we_i       <= 1'b0;
    cur_req_code   = rq;
    cur_resp_code  = rs;
    cur_method_max = ml;
    cur_body_max   = bl;
  endtask

  // Builds one frame for the current settings. Most frames are well formed
  // with random content; the rest are noise, a bad type byte, an illegal
  // method length, a nonzero reserved field, an oversized body length or a
  // frame cut short. Method and body bytes are capped, so declared lengths
  // larger than the cap give frames that end early.
  task automatic build_frame();
    int unsigned flavor;
    int unsigned meth_len;
    int unsigned body_bytes;
    int unsigned extra;
    int unsigned cut;
    bit          resp;
    logic [31:0] id;
    logic [15:0] second;
    frame_bytes.delete();
    flavor = $urandom_range(0, 99);
    if (flavor < 6) begin
      extra = $urandom_range(1, 20);
      repeat (extra) frame_bytes.push_back(8'($urandom));
      return;
    end
    resp     = 1'($urandom);
    id       = $urandom;
    meth_len = 0;
    frame_bytes.push_back(resp ? cur_resp_code : cur_req_code);
    if (flavor < 11) frame_bytes[0] = 8'($urandom);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(id[31:24]);
    frame_bytes.push_back(id[23:16]);
    frame_bytes.push_back(id[15:8]);
    frame_bytes.push_back(id[7:0]);
    if (resp) begin
      second = (flavor < 16) ? 16'($urandom_range(1, 65535)) : 16'd0;
    end else begin
      if (flavor < 16)
        meth_len = ($urandom_range(0, 1) == 0 || cur_method_max == 16'hFFFF) ? 0 :
                   cur_method_max + 1;
      else if ($urandom_range(0, 9) == 0)
        meth_len = cur_method_max;
      else
        meth_len = $urandom_range(1, cur_method_max < 12 ? cur_method_max : 12);
      second = 16'(meth_len);
    end
    frame_bytes.push_back(second[15:8]);
    frame_bytes.push_back(second[7:0]);
    if (!resp) repeat (meth_len < 16 ? meth_len : 16) frame_bytes.push_back(8'($urandom));
    if (flavor >= 16 && flavor < 21)
      body_bytes = (cur_body_max == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : cur_body_max + 1;
    else if ($urandom_range(0, 9) == 0)
      body_bytes = cur_body_max;
    else
      body_bytes = $urandom_range(0, cur_body_max < 20 ? cur_body_max : 20);
    frame_bytes.push_back(body_bytes[31:24]);
    frame_bytes.push_back(body_bytes[23:16]);
    frame_bytes.push_back(body_bytes[15:8]);
    frame_bytes.push_back(body_bytes[7:0]);
    repeat (body_bytes < 24 ? body_bytes : 24) frame_bytes.push_back(8'($urandom));
    // Occasional bytes past the declared body.
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
    if (flavor >= 21 && flavor < 30) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
  endtask

  task automatic run_frames(input int unsigned budget);
    int unsigned stop;
    stop = sent_bytes + budget;
    while (sent_bytes < stop) begin
      build_frame();
      send_frame();
    end
  endtask

  // Input side and sequencing of the run.
  initial begin : frame_source
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_REQ_CODE;
    cfg_data_i        = '0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_byte = 1'b0;
    sent_bytes        = 0;
    send_burst        = 1'b0;
    cur_req_code      = REQ_CODE_RST;
    cur_resp_code     = RESP_CODE_RST;
    cur_method_max    = METHOD_LIMIT_RST;
    cur_body_max      = BODY_LIMIT_RST;
    tag_model         = new();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset settings: the shortest legal request
    // with an all-ones id, the shortest legal response with an all-ones
    // status, and a single byte that is both a bad type and too short.
    frame_bytes = {8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h00};
    send_frame();
    frame_bytes = {8'h02, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00};
    send_frame();
    frame_bytes = {8'hFF};
    send_frame();

    run_frames(120);

    // Lowest limits, request code 00 and response code FF: every body must be
    // empty and one method byte is the most a request may carry.
    wait_idle();
    apply_settings(8'h00, 8'hFF, 16'd1, 32'd0);
    run_frames(330);

    // Highest limits, request code FF and response code 00.
    wait_idle();
    apply_settings(8'hFF, 8'h00, 16'hFFFF, 32'hFFFF_FFFF);
    run_frames(330);

    // Equal type codes: every frame with that type parses as a request.
    wait_idle();
    apply_settings(8'h5A, 8'h5A, 16'd8, 32'd16);
    run_frames(330);

    // Random distinct codes with small limits.
    wait_idle();
    cur_req_code = 8'($urandom);
    apply_settings(cur_req_code, cur_req_code + 8'($urandom_range(1, 255)),
                   16'($urandom_range(1, 40)), 32'($urandom_range(0, 40)));
    run_frames(330);

    // Back to the reset values.
    wait_idle();
    apply_settings(REQ_CODE_RST, RESP_CODE_RST, METHOD_LIMIT_RST, BODY_LIMIT_RST);
    run_frames(330);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (tag_model.mismatches == 0) begin
      $display("tb_rpc_message_deframer_unit: done, clean");
    end else begin
      $display("tb_rpc_message_deframer_unit: done, errors");
    end
    $finish;
  end

  // Output side. Ready follows the same random gap scheme as the sender,
  // except for one long stretch with ready held low so that the internal
  // queue fills and the block has to stall its input channel.
  initial begin : result_sink
    deframe_result_t got;
    int unsigned     gap;
    int unsigned     taken;
    int unsigned     hold;
    bit              burst;
    result_if.ready = 1'b0;
    taken           = 0;
    burst           = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken == HOLD_AFTER) begin
        result_if.ready <= 1'b0;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk_i);
      end else begin
        if (taken % 40 == 0) burst = ($urandom_range(0, 2) == 0);
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
          result_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (result_if.valid !== 1'b1);
      got.kind      = byte_kind_e'(result_if.byte_kind);
      got.value     = result_if.byte_value;
      got.frame_end = result_if.frame_end;
      got.ok        = result_if.frame_ok;
      got.resp      = result_if.is_response;
      got.id        = result_if.rpc_id;
      got.status    = result_if.status_code;
      got.meth_len  = result_if.method_length;
      got.blen      = result_if.body_length;
      tag_model.check_result(got);
      taken++;
    end
  end

  // A hang anywhere, such as a result that never arrives, ends here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_rpc_message_deframer_unit: done, errors");
    $finish;
  end

endmodule
